// ----- sv/egm_pkg.sv -----
// Shared types, codes and the step cost table of the gas meter.
package egm_pkg;

  localparam int GasW = 63;
  localparam logic [GasW-1:0] GasMax = {GasW{1'b1}};

  // Action codes on the request channel
  localparam logic [3:0] ActLoad   = 4'd0;
  localparam logic [3:0] ActStep   = 4'd1;
  localparam logic [3:0] ActCommit = 4'd2;
  localparam logic [3:0] ActExp    = 4'd3;
  localparam logic [3:0] ActSstore = 4'd4;
  localparam logic [3:0] ActLog    = 4'd5;
  localparam logic [3:0] ActHash   = 4'd6;
  localparam logic [3:0] ActCopy   = 4'd7;
  localparam logic [3:0] ActMem    = 4'd8;

  // Fixed dynamic costs
  localparam logic [GasW-1:0] SstoreSetGas   = 63'd20000;
  localparam logic [GasW-1:0] SstoreResetGas = 63'd5000;
  localparam logic [63:0] LogMulLimit  = 64'h0FFF_FFFF_FFFF_FFFF; // GasMax / 8
  localparam logic [63:0] CopyMulLimit = 64'h2AAA_AAAA_AAAA_AAAA; // GasMax / 3

  // Operation handed from the front to the back
  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_LOAD   = 3'd1,
    OP_STEP   = 3'd2,
    OP_COMMIT = 3'd3,
    OP_CHARGE = 3'd4,
    OP_REFUND = 3'd5
  } egm_op_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  opcode;
    logic [63:0] amount;
    logic        refund;
    logic [63:0] exponent_word0;
    logic [63:0] exponent_word1;
    logic [63:0] exponent_word2;
    logic [63:0] exponent_word3;
    logic        old_value_zero;
    logic        new_value_zero;
  } egm_req_t;

  typedef struct packed {
    logic [GasW-1:0] gas_left;
    logic [GasW-1:0] charged;
    logic            out_of_gas;
    logic [GasW-1:0] block_cost;
  } egm_rsp_t;

  // Classified request: operation and its already saturated value
  typedef struct packed {
    egm_op_t         op;
    logic [GasW-1:0] value;
  } egm_cmd_t;

  // Tiered step cost per instruction byte; zero when the opcode has no tier
  function automatic logic [14:0] step_cost(input logic [7:0] op);
    logic [14:0] c;
    c = 15'd0;
    if (op >= 8'h60 && op <= 8'h9f) begin
      c = 15'd3;
    end else begin
      unique case (op)
        8'ha0: c = 15'd375;
        8'ha1: c = 15'd750;
        8'ha2: c = 15'd1125;
        8'ha3: c = 15'd1500;
        8'ha4: c = 15'd1875;
        8'h30, 8'h32, 8'h33, 8'h34, 8'h36, 8'h38, 8'h3a, 8'h41, 8'h42,
        8'h43, 8'h44, 8'h45, 8'h50, 8'h58, 8'h59, 8'h5a: c = 15'd2;
        8'h01, 8'h03, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16,
        8'h17, 8'h18, 8'h19, 8'h1a, 8'h35, 8'h37, 8'h39, 8'h51, 8'h52,
        8'h53: c = 15'd3;
        8'h02, 8'h04, 8'h05, 8'h06, 8'h07, 8'h0b: c = 15'd5;
        8'h08, 8'h09, 8'h56: c = 15'd8;
        8'h0a, 8'h57: c = 15'd10;
        8'h31, 8'h3b, 8'h3c, 8'h40: c = 15'd20;
        8'h20: c = 15'd30;
        8'h54: c = 15'd50;
        8'h5b: c = 15'd1;
        8'hf1, 8'hf2: c = 15'd40;
        8'hf0: c = 15'd32000;
        default: c = 15'd0;
      endcase
    end
    return c;
  endfunction

endpackage

// ----- sv/egm_front.sv -----
// Front end: classifies a request and works out its saturated cost.
module egm_front (
  input  egm_pkg::egm_req_t req,
  output egm_pkg::egm_cmd_t cmd
);
  import egm_pkg::*;

  logic [255:0]    exp_word;
  logic [31:0]     byte_nz;
  logic [5:0]      exp_bytes;
  logic [8:0]      exp_cost;
  logic [59:0]     hash_words;
  logic [GasW-1:0] amount_cap;
  logic [GasW-1:0] log_cost;
  logic [GasW-1:0] hash_cost;
  logic [GasW-1:0] copy_cost;
  logic [64:0]     copy_sum;
  logic [62:0]     hash_sum;

  // Significant bytes of the exponent: highest nonzero byte plus one
  assign exp_word = {req.exponent_word3, req.exponent_word2,
                     req.exponent_word1, req.exponent_word0};

  always_comb begin
    exp_bytes = 6'd0;
    for (int i = 0; i < 32; i++) begin
      byte_nz[i] = |exp_word[8*i +: 8];
      if (byte_nz[i]) begin
        exp_bytes = 6'(i + 1);
      end
    end
  end

  assign exp_cost = {exp_bytes, 3'b000} + {2'b00, exp_bytes, 1'b0};

  // Saturating scaled costs
  assign amount_cap = req.amount[63] ? GasMax : req.amount[62:0];
  assign log_cost   = (req.amount > LogMulLimit) ? GasMax : {req.amount[59:0], 3'b000};

  assign copy_sum  = {req.amount, 1'b0} + {1'b0, req.amount};
  assign copy_cost = (req.amount > CopyMulLimit) ? GasMax : copy_sum[62:0];

  // At most 2^59 words, so six per word stays below GasMax
  assign hash_words = {1'b0, req.amount[63:5]} + {59'd0, |req.amount[4:0]};
  assign hash_sum   = {1'b0, hash_words, 2'b00} + {2'b00, hash_words, 1'b0};
  assign hash_cost  = hash_sum;

  // Classification
  always_comb begin
    cmd.op    = OP_NOP;
    cmd.value = '0;
    unique case (req.action)
      ActLoad: begin
        cmd.op    = OP_LOAD;
        cmd.value = amount_cap;
      end
      ActStep: begin
        cmd.op    = OP_STEP;
        cmd.value = {48'd0, step_cost(req.opcode)};
      end
      ActCommit: cmd.op = OP_COMMIT;
      ActExp: begin
        cmd.op    = OP_CHARGE;
        cmd.value = {54'd0, exp_cost};
      end
      ActSstore: begin
        cmd.op    = OP_CHARGE;
        cmd.value = (req.old_value_zero && !req.new_value_zero) ? SstoreSetGas
                                                                 : SstoreResetGas;
      end
      ActLog: begin
        cmd.op    = OP_CHARGE;
        cmd.value = log_cost;
      end
      ActHash: begin
        cmd.op    = OP_CHARGE;
        cmd.value = hash_cost;
      end
      ActCopy: begin
        cmd.op    = OP_CHARGE;
        cmd.value = copy_cost;
      end
      ActMem: begin
        cmd.op    = req.refund ? OP_REFUND : OP_CHARGE;
        cmd.value = amount_cap;
      end
      default: begin
        cmd.op    = OP_NOP;
        cmd.value = '0;
      end
    endcase
  end

endmodule

// ----- sv/egm_queue.sv -----
// Small flop-based FIFO between the front end and the gas update stage.
module egm_queue #(
  parameter int Depth = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  egm_pkg::egm_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output egm_pkg::egm_cmd_t pop_data
);
  import egm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  egm_cmd_t        entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == FullCnt);
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_data = entries[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/egm_back.sv -----
// Back end: holds gas state, applies one command a cycle unless stalled, registers the response.
module egm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  egm_pkg::egm_cmd_t cmd,
  output logic              cmd_pop,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output egm_pkg::egm_rsp_t rsp
);
  import egm_pkg::*;

  logic [GasW-1:0] remaining_gas;
  logic [GasW-1:0] pending_cost;
  logic            halted;
  logic [GasW-1:0] remaining_gas_next;
  logic [GasW-1:0] pending_cost_next;
  logic            halted_next;
  logic [GasW-1:0] cost;
  logic            do_charge;
  logic [GasW:0]   step_sum;
  logic [GasW:0]   refund_sum;

  // Take a command when the response register is free or being emptied
  assign cmd_pop = cmd_valid && (!rsp_valid || !rsp_stall);

  assign step_sum   = {1'b0, pending_cost} + {1'b0, cmd.value};
  assign refund_sum = {1'b0, remaining_gas} + {1'b0, cmd.value};

  // Gas update
  always_comb begin
    remaining_gas_next = remaining_gas;
    pending_cost_next  = pending_cost;
    halted_next        = halted;
    cost               = '0;
    do_charge          = 1'b0;
    unique case (cmd.op)
      OP_LOAD:   remaining_gas_next = cmd.value;
      OP_STEP:   pending_cost_next  = step_sum[GasW] ? GasMax : step_sum[GasW-1:0];
      OP_COMMIT: begin
        cost              = pending_cost;
        do_charge         = 1'b1;
        pending_cost_next = '0;
      end
      OP_CHARGE: begin
        cost      = cmd.value;
        do_charge = 1'b1;
      end
      OP_REFUND: remaining_gas_next = refund_sum[GasW] ? GasMax : refund_sum[GasW-1:0];
      default: ;
    endcase
    if (do_charge) begin
      if (cost <= remaining_gas) begin
        remaining_gas_next = remaining_gas - cost;
      end else begin
        halted_next = 1'b1;
      end
    end
  end

  // State and control
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_gas <= '0;
      pending_cost  <= '0;
      halted        <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cmd_pop) begin
        remaining_gas <= remaining_gas_next;
        pending_cost  <= pending_cost_next;
        halted        <= halted_next;
        rsp_valid     <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rsp.gas_left   <= remaining_gas_next;
      rsp.charged    <= cost;
      rsp.out_of_gas <= halted_next;
      rsp.block_cost <= pending_cost_next;
    end
  end

endmodule

// ----- sv/evm_gas_meter.sv -----
// Top level of the runtime gas meter: front end, command queue, gas update stage.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries one action per
//   request: load, step, commit, a dynamic charge, or a memory charge/refund.
//   Response channel (rsp_valid / rsp_stall / rsp) returns one response per
//   request, in order: gas left, cost checked, sticky out-of-gas flag and
//   the pending block cost, all after the request.
//   An accepted request is written into the queue, then taken by the gas
//   update stage, which holds its result in the response register.
//   Throughput: one request per cycle while the response is not stalled; the gas
//   update is a single subtract-and-compare against the remaining gas.
//   Stall: when rsp_stall holds the response, the update stage waits and the
//   queue (QueueDepth entries) fills; req_stall rises only when it is full.
//   Reset: synchronous; gas, pending cost and the out-of-gas flag clear,
//   the queue empties, and requests are taken in the next cycle.
module evm_gas_meter #(
  parameter int QueueDepth = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  egm_pkg::egm_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output egm_pkg::egm_rsp_t rsp
);
  import egm_pkg::*;

  egm_cmd_t front_cmd;
  egm_cmd_t queue_cmd;
  logic     queue_full;
  logic     queue_nonempty;
  logic     back_pop;

  assign req_stall = queue_full;

  egm_front u_front (
    .req (req),
    .cmd (front_cmd)
  );

  egm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (back_pop),
    .nonempty  (queue_nonempty),
    .pop_data  (queue_cmd)
  );

  egm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_nonempty),
    .cmd       (queue_cmd),
    .cmd_pop   (back_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- verif/egm_meter_checker.sv -----
// Scoreboard for the gas meter: tracks gas state per request and checks every response.
`timescale 1ns / 1ps

module egm_meter_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  egm_pkg::egm_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  egm_pkg::egm_rsp_t rsp,
  output int                mismatches,
  output int                in_flight,
  output int                responses_checked,
  output int                charges_refused
);
  import egm_pkg::*;

  localparam logic [63:0] GasCap      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ExpByteGas  = 64'd10;
  localparam logic [63:0] LogByteGas  = 64'd8;
  localparam logic [63:0] HashWordGas = 64'd6;
  localparam logic [63:0] CopyWordGas = 64'd3;

  // Meter state as seen after every accepted request
  logic [63:0] gas_q;
  logic [63:0] block_q;
  logic        dry_q;

  egm_rsp_t expected_rsp[$];

  function automatic logic [63:0] clip(input logic [63:0] a);
    return (a > GasCap) ? GasCap : a;
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    return (b > GasCap - a) ? GasCap : a + b;
  endfunction

  function automatic logic [63:0] sat_times(input logic [63:0] a, input logic [63:0] k);
    return (a > GasCap / k) ? GasCap : a * k;
  endfunction

  // Frontier tier price of one instruction byte
  function automatic logic [63:0] tier_cost(input logic [7:0] op);
    logic [63:0] c;
    c = 64'd0;
    if (op >= 8'h60 && op <= 8'h9f) begin
      c = 64'd3;
    end else if (op >= 8'ha0 && op <= 8'ha4) begin
      c = 64'd375 * (64'(op - 8'ha0) + 64'd1);
    end else begin
      case (op)
        8'h5b: c = 64'd1;
        8'h30, 8'h32, 8'h33, 8'h34, 8'h36, 8'h38, 8'h3a, 8'h41, 8'h42, 8'h43,
        8'h44, 8'h45, 8'h50, 8'h58, 8'h59, 8'h5a: c = 64'd2;
        8'h01, 8'h03, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
        8'h18, 8'h19, 8'h1a, 8'h35, 8'h37, 8'h39, 8'h51, 8'h52, 8'h53: c = 64'd3;
        8'h02, 8'h04, 8'h05, 8'h06, 8'h07, 8'h0b: c = 64'd5;
        8'h08, 8'h09, 8'h56: c = 64'd8;
        8'h0a, 8'h57: c = 64'd10;
        8'h31, 8'h3b, 8'h3c, 8'h40: c = 64'd20;
        8'h20: c = 64'd30;
        8'hf1, 8'hf2: c = 64'd40;
        8'h54: c = 64'd50;
        8'hf0: c = 64'd32000;
        default: c = 64'd0;
      endcase
    end
    return c;
  endfunction

  // Significant bytes of the 256-bit exponent; highest nonzero word wins
  function automatic logic [63:0] exponent_bytes(input egm_req_t r);
    logic [63:0] w [4];
    logic [63:0] n;
    int          bits;
    w[0] = r.exponent_word0;
    w[1] = r.exponent_word1;
    w[2] = r.exponent_word2;
    w[3] = r.exponent_word3;
    n = 64'd0;
    for (int i = 0; i < 4; i++) begin
      if (w[i] != 64'd0) begin
        bits = 0;
        for (int b = 0; b < 64; b++) begin
          if (w[i][b]) bits = b + 1;
        end
        n = 64'(i * 8 + (bits + 7) / 8);
      end
    end
    return n;
  endfunction

  // Apply one request to the tracked state and build its response
  task automatic meter_update(input egm_req_t r, output egm_rsp_t e);
    logic [63:0] cost;
    logic [63:0] words;
    logic        take;
    cost = 64'd0;
    take = 1'b0;
    case (r.action)
      ActLoad: gas_q = clip(r.amount);
      ActStep: block_q = sat_sum(block_q, tier_cost(r.opcode));
      ActCommit: begin
        // empty block is not checked; a refused block is dropped anyway
        if (block_q != 64'd0) begin
          cost = block_q;
          take = 1'b1;
        end
        block_q = 64'd0;
      end
      ActExp: begin
        cost = exponent_bytes(r) * ExpByteGas;
        take = 1'b1;
      end
      ActSstore: begin
        cost = (r.old_value_zero && !r.new_value_zero) ? 64'(SstoreSetGas)
                                                       : 64'(SstoreResetGas);
        take = 1'b1;
      end
      ActLog: begin
        cost = sat_times(r.amount, LogByteGas);
        take = 1'b1;
      end
      ActHash: begin
        words = (r.amount >> 5) + ((r.amount[4:0] != 5'd0) ? 64'd1 : 64'd0);
        cost  = sat_times(words, HashWordGas);
        take  = 1'b1;
      end
      ActCopy: begin
        cost = sat_times(r.amount, CopyWordGas);
        take = 1'b1;
      end
      ActMem: begin
        if (r.refund) begin
          gas_q = sat_sum(gas_q, clip(r.amount));
        end else begin
          cost = clip(r.amount);
          take = 1'b1;
        end
      end
      default: ;
    endcase
    // charge only when it fits, otherwise latch out of gas
    if (take) begin
      if (cost <= gas_q) begin
        gas_q = gas_q - cost;
      end else begin
        dry_q = 1'b1;
        charges_refused++;
      end
    end
    e.gas_left   = gas_q[62:0];
    e.charged    = cost[62:0];
    e.out_of_gas = dry_q;
    e.block_cost = block_q[62:0];
  endtask

  task automatic check_field(input string field, input logic [62:0] want,
                             input logic [62:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Responses are matched first so one with nothing outstanding is caught
  always @(posedge clk) begin
    egm_rsp_t want;
    egm_rsp_t next;
    if (rst) begin
      gas_q   = 64'd0;
      block_q = 64'd0;
      dry_q   = 1'b0;
      expected_rsp.delete();
      in_flight <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("response: expected none, got gas_left %0d", rsp.gas_left);
          mismatches++;
        end else begin
          want = expected_rsp.pop_front();
          check_field("gas_left", want.gas_left, rsp.gas_left);
          check_field("charged", want.charged, rsp.charged);
          check_field("out_of_gas", 63'(want.out_of_gas), 63'(rsp.out_of_gas));
          check_field("block_cost", want.block_cost, rsp.block_cost);
          responses_checked++;
        end
      end
      if (req_valid && !req_stall) begin
        meter_update(req, next);
        expected_rsp.push_back(next);
      end
      in_flight <= expected_rsp.size();
    end
  end

endmodule

// ----- verif/tb_evm_gas_meter.sv -----
// Testbench top for the gas meter: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module tb_evm_gas_meter;
  import egm_pkg::*;

  localparam logic [63:0] GasCap        = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [3:0]  ActionMax     = 4'hf;
  localparam int          RandomPerPass = 600;
  localparam int          QuietLimit    = 2000;
  localparam int          DrainCycles   = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  egm_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  egm_rsp_t rsp;

  int mismatches;
  int in_flight;
  int responses_checked;
  int charges_refused;
  int requests_sent = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 35;
  int stall_pct = 71;

  always #1 clk = ~clk;

  evm_gas_meter u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  egm_meter_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req              (req),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .rsp              (rsp),
    .mismatches       (mismatches),
    .in_flight        (in_flight),
    .responses_checked(responses_checked),
    .charges_refused  (charges_refused)
  );

  // Response back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Hang detection: no request or response moving for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("evm_gas_meter regression: fail");
        $finish;
      end
    end
  end

  // Saturation and rounding edges of the amount field
  function automatic logic [63:0] edge_amount(input int k);
    case (k)
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'd31;
      3: return 64'd32;
      4: return 64'd33;
      5: return GasCap;
      6: return GasCap + 64'd1;
      7: return '1;
      8: return LogMulLimit;
      9: return LogMulLimit + 64'd1;
      10: return CopyMulLimit;
      11: return CopyMulLimit + 64'd1;
      12: return 64'hAAAA_AAAA_AAAA_AAA0;
      default: return 64'hAAAA_AAAA_AAAA_AAA1;
    endcase
  endfunction

  // Mostly small amounts so charges fit, with wide and edge values mixed in
  function automatic logic [63:0] pick_amount();
    case ($urandom_range(9))
      0: return 64'd0;
      1, 2, 3, 4: return 64'($urandom_range(0, 4096));
      5: return {$urandom, $urandom};
      6: return {$urandom, $urandom} >> $urandom_range(63);
      7, 8: return edge_amount($urandom_range(13));
      default: return 64'($urandom_range(0, 100000));
    endcase
  endfunction

  function automatic egm_req_t plain_request(input logic [3:0] act, input logic [63:0] amt);
    egm_req_t r;
    r = '0;
    r.action = act;
    r.amount = amt;
    return r;
  endfunction

  // Random request: every field random, then the one that matters shaped
  function automatic egm_req_t random_request();
    egm_req_t    r;
    logic [63:0] w [4];
    int          pick;
    int          top_word;
    pick     = $urandom_range(99);
    top_word = $urandom_range(4);
    for (int i = 0; i < 4; i++) w[i] = {$urandom, $urandom};
    r.opcode         = 8'($urandom);
    r.amount         = pick_amount();
    r.refund         = 1'($urandom);
    r.old_value_zero = 1'($urandom);
    r.new_value_zero = 1'($urandom);
    if (pick < 8) begin
      r.action = ActLoad;
      if ($urandom_range(3) != 0) r.amount = 64'($urandom_range(0, 2000000));
    end else if (pick < 43) begin
      r.action = ActStep;
    end else if (pick < 55) begin
      r.action = ActCommit;
    end else if (pick < 62) begin
      // top_word of 4 gives a zero exponent
      r.action = ActExp;
      for (int i = 0; i < 4; i++) begin
        if (i > top_word || top_word == 4) w[i] = 64'd0;
      end
      if (top_word < 4) begin
        w[top_word] = {$urandom, $urandom} >> $urandom_range(63);
        if (w[top_word] == 64'd0) w[top_word] = 64'd1;
      end
    end else if (pick < 68) begin
      r.action = ActSstore;
    end else if (pick < 74) begin
      r.action = ActLog;
    end else if (pick < 80) begin
      r.action = ActHash;
    end else if (pick < 86) begin
      r.action = ActCopy;
    end else if (pick < 96) begin
      r.action = ActMem;
    end else begin
      r.action = 4'($urandom_range(ActMem + 1, ActionMax));
    end
    r.exponent_word0 = w[0];
    r.exponent_word1 = w[1];
    r.exponent_word2 = w[2];
    r.exponent_word3 = w[3];
    return r;
  endfunction

  // Offer one request, with random idle cycles first, and hold it until taken
  task automatic send_request(input egm_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    requests_sent++;
  endtask

  initial begin
    egm_req_t   d;
    logic [7:0] probe_ops [6];
    probe_ops = '{8'h01, 8'h9f, 8'ha4, 8'hf0, 8'h5b, 8'hfe};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero charge on zero gas, saturating load and refund
    send_request(plain_request(ActMem, 64'd0));
    send_request(plain_request(ActLoad, '1));
    d = plain_request(ActMem, GasCap);
    d.refund = 1'b1;
    send_request(d);
    send_request(plain_request(ActCommit, 64'd0));

    // Tier extremes and an untiered opcode, then commit the block
    for (int i = 0; i < 6; i++) begin
      d = plain_request(ActStep, 64'd0);
      d.opcode = probe_ops[i];
      send_request(d);
    end
    send_request(plain_request(ActCommit, 64'd0));

    // Exponent: zero, full 32 bytes, single byte
    send_request(plain_request(ActExp, 64'd0));
    d = plain_request(ActExp, 64'd0);
    d.exponent_word3 = '1;
    send_request(d);
    d = plain_request(ActExp, 64'd0);
    d.exponent_word0 = 64'd1;
    send_request(d);

    // Storage writes: set, zero-to-zero, overwrite
    d = plain_request(ActSstore, 64'd0);
    d.old_value_zero = 1'b1;
    send_request(d);
    d.new_value_zero = 1'b1;
    send_request(d);
    d.old_value_zero = 1'b0;
    d.new_value_zero = 1'b0;
    send_request(d);
    send_request(plain_request(ActHash, 64'd33));

    // Refused commit clears the block and raises out of gas
    send_request(plain_request(ActLoad, 64'd100));
    d = plain_request(ActStep, 64'd0);
    d.opcode = 8'hf0;
    send_request(d);
    send_request(plain_request(ActCommit, 64'd0));

    // Saturating dynamic costs after out of gas, refund, unused action
    send_request(plain_request(ActHash, '1));
    send_request(plain_request(ActCopy, CopyMulLimit + 64'd1));
    send_request(plain_request(ActLog, LogMulLimit + 64'd1));
    send_request(plain_request(ActMem, '1));
    d = plain_request(ActMem, 64'd1000);
    d.refund = 1'b1;
    send_request(d);
    send_request(plain_request(ActionMax, '1));

    // Random traffic under three idling profiles
    for (int pass = 0; pass < 3; pass++) begin
      if (pass == 1) begin
        send_idle_pct <= 71;
        stall_pct     <= 35;
      end else if (pass == 2) begin
        send_idle_pct <= 0;
        stall_pct     <= 0;
      end
      for (int n = 0; n < RandomPerPass; n++) send_request(random_request());
    end
    req_valid <= 1'b0;

    // Drain outstanding responses, then a short quiet tail
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d requests (corner cases, then random traffic under three idle mixes).",
             requests_sent);
    $display("Checked %0d responses; %0d charges were refused for lack of gas.",
             responses_checked, charges_refused);
    if (mismatches == 0) begin
      $display("evm_gas_meter regression: pass");
    end else begin
      $display("evm_gas_meter regression: fail");
    end
    $finish;
  end

endmodule
